// ===== sv/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg - shared types and constants of the flux interval rescaler
// Register indexes, field widths and the result group of the scaling unit.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int RATE_W      = 16;
	localparam int POS_W       = 24;
	localparam int TICKS_W     = 32;
	localparam int FRAC_W      = 4;
	localparam int COUNT_W     = 12;
	localparam int SLOT_W      = 3;
	localparam int IDX_W       = 3;
	localparam int CFG_W       = 32;

	localparam int NUM_REV_SLOTS = 5;
	localparam int NUM_LEN_REGS  = 5;

	localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(7372);
	localparam logic [POS_W-1:0]  REV_LEN_RESET = POS_W'(1);

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_RATE_SCALE  = 3'd0,
		REG_START_POS   = 3'd1,
		REG_START_TICKS = 3'd2,
		REG_REV_LEN_0   = 3'd3,
		REG_REV_LEN_1   = 3'd4,
		REG_REV_LEN_2   = 3'd5,
		REG_REV_LEN_3   = 3'd6,
		REG_REV_LEN_4   = 3'd7
	} reg_idx_t;

	// outcome of scaling one sample
	typedef struct packed {
		logic [SAMPLE_W-1:0] scaled;
		logic [COUNT_W-1:0]  tick_count;
		logic [FRAC_W-1:0]   frac_next;
	} scale_res_t;

endpackage

// ===== sv/fir_scale.sv =====
// ----------------------------------------------------------------------------
// fir_scale - sample scaling and remainder split
// Multiplies one interval by the rate factor, clamps, and splits off the
// whole timer ticks against the carried 4-bit fractional remainder.
// ----------------------------------------------------------------------------
module fir_scale
	import fir_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [RATE_W-1:0]   rate,
	input  logic [FRAC_W-1:0]   frac,
	output scale_res_t          res
);

	logic [SAMPLE_W:0]               sample_ext;
	logic [SAMPLE_W+RATE_W:0]        product;
	logic [SAMPLE_W+RATE_W-8:0]      shifted;
	logic [SAMPLE_W-1:0]             scaled;
	logic [SAMPLE_W:0]               sum;
	logic [SAMPLE_W-FRAC_W:0]        whole;
	logic [SAMPLE_W-FRAC_W:0]        whole_m1;

	// zero stands for a full 65536-tick interval
	assign sample_ext = (sample == '0) ? {1'b1, {SAMPLE_W{1'b0}}} : {1'b0, sample};
	assign product    = sample_ext * {{(SAMPLE_W+1){1'b0}}, rate};
	assign shifted    = product[SAMPLE_W+RATE_W:8];

	// clamp to the largest 16-bit value
	assign scaled = (|shifted[SAMPLE_W+RATE_W-8:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
		: shifted[SAMPLE_W-1:0];

	assign sum      = {{(SAMPLE_W+1-FRAC_W){1'b0}}, frac} + {1'b0, scaled};
	assign whole    = sum[SAMPLE_W:FRAC_W];
	assign whole_m1 = whole - {{(SAMPLE_W-FRAC_W){1'b0}}, 1'b1};

	always_comb begin
		res.scaled     = scaled;
		res.frac_next  = sum[FRAC_W-1:0];
		// hold at zero rather than wrap when no whole tick is present
		res.tick_count = (whole == '0) ? '0 : whole_m1[COUNT_W-1:0];
	end

endmodule

// ===== sv/flux_interval_rescaler.sv =====
// ----------------------------------------------------------------------------
// flux_interval_rescaler - flux interval to timer count converter
// Scales flux intervals to output timer counts and tracks revolution slots.
// ----------------------------------------------------------------------------
// Takes one 16-bit flux interval per transfer (0 meaning 65536 source ticks)
// and returns one result per sample: the timer count (whole output ticks
// minus one, held at zero), a flag marking the first sample of a new
// revolution, the elapsed fine-tick length of the revolution just finished,
// and the revolution slot of the sample. One sample is accepted every clock
// cycle while the output does not stall, and passes through the input
// register and then the result register around the single scaling multiply
// and state update. The two registers let a new sample enter while a result
// still waits on a stalled output. Configuration writes take effect at once;
// writing start_position or start_ticks also reloads the position and the
// elapsed total (a seek), so write them only while no sample is in flight.
// ----------------------------------------------------------------------------
module flux_interval_rescaler
	import fir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  flux_sample,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COUNT_W-1:0]   tick_count,
	output logic                 rev_wrapped,
	output logic [TICKS_W-1:0]   track_length,
	output logic [SLOT_W-1:0]    rev_slot,
	// configuration write port
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	// configuration
	logic [RATE_W-1:0]  rate_q;
	logic [POS_W-1:0]   rev_len_q [NUM_LEN_REGS];

	// running state
	logic [FRAC_W-1:0]  frac_q;
	logic [TICKS_W-1:0] elapsed_q;
	logic [POS_W-1:0]   pos_q;
	logic [SLOT_W-1:0]  slot_q;

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic                in_xfer;
	logic                adv;
	logic [SLOT_W-1:0]   slot_cur;
	logic [SLOT_W-1:0]   len_idx;
	logic [POS_W-1:0]    slot_len;
	logic                wrap;
	logic [SLOT_W-1:0]   slot_next;
	logic [POS_W-1:0]    pos_next;
	logic [TICKS_W-1:0]  elapsed_next;
	scale_res_t          scl;

	// Advance the input stage whenever the result register is free or being
	// drained this cycle; stall the source only while a sample waits here.
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// Fold an out-of-range slot back to zero before use.
	assign slot_cur = (slot_q >= SLOT_W'(NUM_REV_SLOTS)) ? '0 : slot_q;
	// Slots past the last length register share it.
	assign len_idx  = (slot_cur >= SLOT_W'(NUM_LEN_REGS)) ? SLOT_W'(NUM_LEN_REGS - 1)
		: slot_cur;
	assign slot_len = rev_len_q[len_idx];

	// Wrap once the position has reached the slot length.
	assign wrap      = (pos_q >= slot_len);
	assign slot_next = !wrap ? slot_cur
		: (slot_cur == SLOT_W'(NUM_REV_SLOTS - 1)) ? '0 : slot_cur + SLOT_W'(1);
	assign pos_next  = (wrap ? '0 : pos_q) + POS_W'(1);
	assign elapsed_next = (wrap ? '0 : elapsed_q)
		+ {{(TICKS_W-SAMPLE_W){1'b0}}, scl.scaled};

	fir_scale u_scale (
		.sample (sample_s1),
		.rate   (rate_q),
		.frac   (frac_q),
		.res    (scl)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			for (int i = 0; i < NUM_LEN_REGS; i++) begin
				rev_len_q[i] <= REV_LEN_RESET;
			end
		end else if (wr_en) begin
			if (wr_index == REG_RATE_SCALE) begin
				rate_q <= wr_data[RATE_W-1:0];
			end
			if (wr_index inside {[REG_REV_LEN_0:REG_REV_LEN_4]}) begin
				rev_len_q[wr_index - IDX_W'(REG_REV_LEN_0)] <= wr_data[POS_W-1:0];
			end
		end
	end

	// Running state: seek writes load position and elapsed total directly,
	// otherwise advance on every sample that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q    <= '0;
			elapsed_q <= '0;
			pos_q     <= '0;
			slot_q    <= '0;
		end else begin
			if (adv) begin
				frac_q    <= scl.frac_next;
				slot_q    <= slot_next;
			end
			if (wr_en && (wr_index == REG_START_POS)) begin
				pos_q <= wr_data[POS_W-1:0];
			end else if (adv) begin
				pos_q <= pos_next;
			end
			if (wr_en && (wr_index == REG_START_TICKS)) begin
				elapsed_q <= wr_data[TICKS_W-1:0];
			end else if (adv) begin
				elapsed_q <= elapsed_next;
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= flux_sample;
		end
	end

	// Result register control: fill on advance, drop once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_count   <= scl.tick_count;
			rev_wrapped  <= wrap;
			track_length <= wrap ? elapsed_q : '0;
			rev_slot     <= slot_next;
		end
	end

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(NUM_REV_SLOTS))
		else $error("revolution slot out of range");

	a_out_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rev_slot < SLOT_W'(NUM_REV_SLOTS)))
		else $error("reported slot out of range");

	a_len_zero_unwrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rev_wrapped) |-> (track_length == '0))
		else $error("track length reported without a wrap");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled with room available");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced sample lost from result register");
`endif

endmodule
